// ===== src/nbf_pkg.sv =====
// nbf_pkg: shared types and constants for the next base fee update pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package nbf_pkg;

  localparam int unsigned FeeW  = 64;
  localparam int unsigned CfgW  = 8;
  localparam int unsigned DvsW  = FeeW + CfgW;
  localparam int unsigned ProdW = 2 * FeeW;
  localparam int unsigned HalfW = FeeW / 2;

  localparam logic [CfgW-1:0] ElasReset = CfgW'(2);
  localparam logic [CfgW-1:0] DenReset  = CfgW'(8);

  // configuration register indexes
  typedef enum logic {
    REG_ELASTICITY = 1'b0,
    REG_DENOMINATOR = 1'b1
  } reg_idx_t;

  // adjustment codes
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_RAISE = 2'd1,
    KIND_LOWER = 2'd2
  } kind_t;

  // sideband carried through the target divider
  typedef struct packed {
    logic [FeeW-1:0] fee;
    logic [FeeW-1:0] used;
    logic [CfgW-1:0] den;
  } side1_t;

  // sideband carried through the fee divider
  typedef struct packed {
    logic [FeeW-1:0] fee;
    kind_t           kind;
    logic            ovf;
  } side2_t;

endpackage
`default_nettype wire

// ===== src/nbf_if.sv =====
// nbf_in_if, nbf_out_if: valid/ready channels for input and result items
// no package dependency; the 64-bit fields match nbf_pkg::FeeW
`timescale 1ns / 1ps
`default_nettype none
interface nbf_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] prev_fee;
  logic [63:0] prev_used;
  logic [63:0] prev_limit;
  modport source (output valid, prev_fee, prev_used, prev_limit, input ready);
  modport sink (input valid, prev_fee, prev_used, prev_limit, output ready);
endinterface

interface nbf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] next_fee;
  logic [1:0]  adjust_kind;
  logic        clipped;
  modport source (output valid, next_fee, adjust_kind, clipped, input ready);
  modport sink (input valid, next_fee, adjust_kind, clipped, output ready);
endinterface
`default_nettype wire

// ===== src/next_base_fee_update.sv =====
// next_base_fee_update: top level, config registers, final adjust and output register
// depends on nbf_pkg, nbf_if, nbf_div, nbf_mul
// An item is taken every cycle while the result register is free or being
// drained; the path from accept to result valid runs through one input
// register, 64 stages of the target divider (limit by elasticity), four
// stages of delta, multiply and overflow check, 64 stages of the fee divider
// (product by target times denominator, one bit per stage), and the result
// register. When the result is not taken the whole pipeline holds. A zero
// written to a configuration register acts as one.
`timescale 1ns / 1ps
`default_nettype none
module next_base_fee_update (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [nbf_pkg::CfgW-1:0]  cfg_data,
  nbf_in_if.sink                         in_ch,
  nbf_out_if.source                      out_ch
);
  import nbf_pkg::*;

  logic [CfgW-1:0] elas, den;
  logic            en;
  logic            s0_valid;
  logic [FeeW-1:0] s0_limit;
  logic [CfgW-1:0] s0_elas;
  side1_t          s0_side;
  logic            d1_valid;
  logic [FeeW-1:0] d1_target;
  logic [$bits(side1_t)-1:0] d1_side_raw;
  side1_t          d1_side;
  logic            m_valid;
  logic [FeeW-1:0] m_prod_lo;
  logic [DvsW-1:0] m_rem, m_dvs;
  side2_t          m_side;
  logic            d2_valid;
  logic [FeeW-1:0] d2_quo;
  logic [$bits(side2_t)-1:0] d2_side_raw;
  side2_t          d2_side;
  logic [FeeW-1:0] fee_next;
  logic            clip_next;
  logic [FeeW-1:0] change;
  logic [FeeW:0]   raised;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      elas <= ElasReset;
      den  <= DenReset;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ELASTICITY:  elas <= cfg_data;
        REG_DENOMINATOR: den  <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance, held by a waiting result
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_limit     <= in_ch.prev_limit;
      s0_elas      <= (elas == '0) ? CfgW'(1) : elas;
      s0_side.fee  <= in_ch.prev_fee;
      s0_side.used <= in_ch.prev_used;
      s0_side.den  <= den;
    end
  end

  // target = limit / elasticity
  nbf_div #(.NW(FeeW), .DW(CfgW), .SW($bits(side1_t))) u_tdiv (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s0_valid), .num(s0_limit), .dvs(s0_elas), .rem_init('0),
    .side(s0_side),
    .out_valid(d1_valid), .quo(d1_target), .out_side(d1_side_raw)
  );
  assign d1_side = side1_t'(d1_side_raw);

  nbf_mul u_mul (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d1_valid), .target(d1_target), .in_side(d1_side),
    .out_valid(m_valid), .prod_lo(m_prod_lo), .rem_init(m_rem), .dvs(m_dvs),
    .out_side(m_side)
  );

  // change = product / (target * denominator), low 64 quotient bits
  nbf_div #(.NW(FeeW), .DW(DvsW), .SW($bits(side2_t))) u_fdiv (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(m_valid), .num(m_prod_lo), .dvs(m_dvs), .rem_init(m_rem),
    .side(m_side),
    .out_valid(d2_valid), .quo(d2_quo), .out_side(d2_side_raw)
  );
  assign d2_side = side2_t'(d2_side_raw);

  // apply the change with saturation and floor
  assign change = (d2_side.kind == KIND_RAISE && d2_quo == '0) ? FeeW'(1) : d2_quo;
  assign raised = {1'b0, d2_side.fee} + {1'b0, change};

  always_comb begin
    fee_next  = d2_side.fee;
    clip_next = 1'b0;
    unique case (d2_side.kind)
      KIND_RAISE: begin
        if (d2_side.ovf || raised[FeeW]) begin
          fee_next  = '1;
          clip_next = 1'b1;
        end else begin
          fee_next = raised[FeeW-1:0];
        end
      end
      KIND_LOWER: begin
        if (d2_side.ovf) begin
          fee_next  = '0;
          clip_next = 1'b1;
        end else if (change >= d2_side.fee) begin
          fee_next  = '0;
          clip_next = change > d2_side.fee;
        end else begin
          fee_next = d2_side.fee - change;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.next_fee    <= fee_next;
      out_ch.adjust_kind <= d2_side.kind;
      out_ch.clipped     <= clip_next;
    end
  end

  // checks
  a_no_clip_unchanged: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.adjust_kind == KIND_NONE |-> !out_ch.clipped)
    else $error("clipped set on unchanged fee");

  a_raise_clip_max: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.adjust_kind == KIND_RAISE && out_ch.clipped |->
      out_ch.next_fee == '1)
    else $error("raised clip not at maximum");

  a_lower_clip_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.adjust_kind == KIND_LOWER && out_ch.clipped |->
      out_ch.next_fee == '0)
    else $error("lowered clip not at zero");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline held");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.next_fee))
    else $error("held result changed");

endmodule
`default_nettype wire

// ===== src/nbf_div.sv =====
// nbf_div: pipelined restoring divider, one quotient bit per stage
// generic; no package dependency
`timescale 1ns / 1ps
`default_nettype none
module nbf_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 8,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] dvs,
  input  wire logic [DW-1:0] rem_init,
  input  wire logic [SW-1:0] side,
  output logic               out_valid,
  output logic [NW-1:0]      quo,
  output logic [SW-1:0]      out_side
);

  logic          vld [1:NW];
  logic [DW-1:0] rem [1:NW];
  logic [NW-1:0] nm  [1:NW];
  logic [NW-1:0] qu  [1:NW];
  logic [DW-1:0] dv  [1:NW];
  logic [SW-1:0] sd  [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          p_vld;
    logic [DW-1:0] p_rem;
    logic [NW-1:0] p_nm;
    logic [NW-1:0] p_qu;
    logic [DW-1:0] p_dv;
    logic [SW-1:0] p_sd;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          take;

    if (k == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_rem = rem_init;
      assign p_nm  = num;
      assign p_qu  = '0;
      assign p_dv  = dvs;
      assign p_sd  = side;
    end else begin : g_mid
      assign p_vld = vld[k];
      assign p_rem = rem[k];
      assign p_nm  = nm[k];
      assign p_qu  = qu[k];
      assign p_dv  = dv[k];
      assign p_sd  = sd[k];
    end

    // one compare and subtract step
    assign shifted = {p_rem, p_nm[NW-1]};
    assign diff    = shifted - {1'b0, p_dv};
    assign take    = shifted >= {1'b0, p_dv};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? diff[DW-1:0] : shifted[DW-1:0];
        nm[k+1]  <= {p_nm[NW-2:0], 1'b0};
        qu[k+1]  <= {p_qu[NW-2:0], take};
        dv[k+1]  <= p_dv;
        sd[k+1]  <= p_sd;
      end
    end
  end

  assign out_valid = vld[NW];
  assign quo       = qu[NW];
  assign out_side  = sd[NW];

endmodule
`default_nettype wire

// ===== src/nbf_mul.sv =====
// nbf_mul: delta, 128-bit product and overflow check ahead of the fee divider
// depends on nbf_pkg
`timescale 1ns / 1ps
`default_nettype none
module nbf_mul (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [nbf_pkg::FeeW-1:0]   target,
  input  wire nbf_pkg::side1_t            in_side,
  output logic                            out_valid,
  output logic [nbf_pkg::FeeW-1:0]        prod_lo,
  output logic [nbf_pkg::DvsW-1:0]        rem_init,
  output logic [nbf_pkg::DvsW-1:0]        dvs,
  output nbf_pkg::side2_t                 out_side
);
  import nbf_pkg::*;

  logic              va, vb, vc;
  logic [FeeW-1:0]   a_fee, a_delta, a_target;
  logic [CfgW-1:0]   a_den;
  kind_t             a_kind, b_kind, c_kind;
  logic [FeeW-1:0]   b_fee, c_fee;
  logic [FeeW-1:0]   p00, p01, p10, p11;
  logic [DvsW-1:0]   b_dvs, c_dvs;
  logic [ProdW-1:0]  c_prod;
  logic [ProdW-1:0]  prod_sum;
  logic              ovf_c;
  kind_t             kind_a_next;

  // direction of change
  always_comb begin
    if (target == '0 || in_side.used == target) begin
      kind_a_next = KIND_NONE;
    end else if (in_side.used > target) begin
      kind_a_next = KIND_RAISE;
    end else begin
      kind_a_next = KIND_LOWER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      out_valid <= vc;
    end
  end

  // stage a: delta and kind
  always_ff @(posedge clk) begin
    if (en) begin
      a_fee    <= in_side.fee;
      a_target <= target;
      a_den    <= (in_side.den == '0) ? CfgW'(1) : in_side.den;
      a_kind   <= kind_a_next;
      a_delta  <= (in_side.used > target) ? in_side.used - target : target - in_side.used;
    end
  end

  // stage b: partial products and combined divisor
  always_ff @(posedge clk) begin
    if (en) begin
      p00    <= a_fee[HalfW-1:0]    * a_delta[HalfW-1:0];
      p01    <= a_fee[HalfW-1:0]    * a_delta[FeeW-1:HalfW];
      p10    <= a_fee[FeeW-1:HalfW] * a_delta[HalfW-1:0];
      p11    <= a_fee[FeeW-1:HalfW] * a_delta[FeeW-1:HalfW];
      b_dvs  <= DvsW'(a_target) * DvsW'(a_den);
      b_fee  <= a_fee;
      b_kind <= a_kind;
    end
  end

  // stage c: sum partial products
  assign prod_sum = {p11, p00} + (ProdW'(p01) << HalfW) + (ProdW'(p10) << HalfW);

  always_ff @(posedge clk) begin
    if (en) begin
      c_prod <= prod_sum;
      c_dvs  <= b_dvs;
      c_fee  <= b_fee;
      c_kind <= b_kind;
    end
  end

  // stage d: quotient overflow check, starting remainder
  assign ovf_c = DvsW'(c_prod[ProdW-1:FeeW]) >= c_dvs;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_lo       <= c_prod[FeeW-1:0];
      rem_init      <= ovf_c ? '0 : DvsW'(c_prod[ProdW-1:FeeW]);
      dvs           <= c_dvs;
      out_side.fee  <= c_fee;
      out_side.kind <= c_kind;
      out_side.ovf  <= ovf_c;
    end
  end

endmodule
`default_nettype wire
